/* hw/rtl/x86alu_pkg.sv */
// ----------------------------------------------------------------------------
// x86alu_pkg
// Shared types and codes for the x86-style integer ALU with flags.
// ----------------------------------------------------------------------------
`default_nettype none

package x86alu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 4;
  localparam int unsigned SizeW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 4'd0,
    CMD_ADC = 4'd1,
    CMD_SUB = 4'd2,
    CMD_SBB = 4'd3,
    CMD_AND = 4'd4,
    CMD_OR  = 4'd5,
    CMD_XOR = 4'd6,
    CMD_SHL = 4'd7,
    CMD_SHR = 4'd8
  } cmd_e;

  typedef enum logic [SizeW-1:0] {
    SZ_8  = 2'd0,
    SZ_16 = 2'd1,
    SZ_32 = 2'd2
  } size_e;

  typedef struct packed {
    logic cf;
    logic pf;
    logic zf;
    logic sf;
    logic of;
  } flags_t;

endpackage

`default_nettype wire

/* hw/rtl/x86alu_core.sv */
// ----------------------------------------------------------------------------
// x86alu_core
// Single-pass ALU datapath: result and next flags from one request and the
// stored flags.
// ----------------------------------------------------------------------------
`default_nettype none

module x86alu_core
  import x86alu_pkg::*;
(
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [DataW-1:0] src_i,
  input  logic [DataW-1:0] dest_i,
  input  logic [SizeW-1:0] size_i,
  input  flags_t           flags_i,
  output logic [DataW-1:0] result_o,
  output flags_t           flags_o
);

  function automatic logic msb_of(input logic [DataW-1:0] v, input logic [SizeW-1:0] sz);
    logic b;
    case (sz)
      SZ_8:    b = v[7];
      SZ_16:   b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

  function automatic logic carry_of(input logic [DataW:0] t, input logic [SizeW-1:0] sz);
    logic b;
    case (sz)
      SZ_8:    b = t[8];
      SZ_16:   b = t[16];
      default: b = t[32];
    endcase
    return b;
  endfunction

  logic [DataW-1:0]   mask;
  logic [5:0]         width;
  logic [DataW-1:0]   s_m;
  logic [DataW-1:0]   d_m;
  logic               cin;
  logic [DataW:0]     add_t;
  logic [DataW:0]     sub_t;
  logic               borrow;
  logic [DataW:0]     shl_t;
  logic [DataW:0]     shr_t;
  logic               cnt_zero;
  logic               cnt_one;
  logic               cnt_lt;
  logic               cnt_eq;
  logic [DataW-1:0]   res;
  flags_t             nf;
  logic               upd_res;

  always_comb begin
    case (size_e'(size_i))
      SZ_8: begin
        mask  = 32'h0000_00FF;
        width = 6'd8;
      end
      SZ_16: begin
        mask  = 32'h0000_FFFF;
        width = 6'd16;
      end
      default: begin
        mask  = 32'hFFFF_FFFF;
        width = 6'd32;
      end
    endcase
  end

  assign s_m    = src_i & mask;
  assign d_m    = dest_i & mask;
  assign cin    = ((cmd_e'(cmd_i) == CMD_ADC) || (cmd_e'(cmd_i) == CMD_SBB)) ? flags_i.cf : 1'b0;
  assign add_t  = {1'b0, d_m} + {1'b0, s_m} + {{DataW{1'b0}}, cin};
  assign sub_t  = {1'b0, d_m} - {1'b0, s_m} - {{DataW{1'b0}}, cin};
  assign borrow = {1'b0, d_m} < ({1'b0, s_m} + {{DataW{1'b0}}, cin});

  // full unmasked count governs the shifts
  assign cnt_zero = (src_i == '0);
  assign cnt_one  = (src_i == {{(DataW-1){1'b0}}, 1'b1});
  assign cnt_lt   = (src_i < {{(DataW-6){1'b0}}, width});
  assign cnt_eq   = (src_i == {{(DataW-6){1'b0}}, width});
  assign shl_t    = {1'b0, d_m} << src_i[4:0];
  assign shr_t    = {d_m, 1'b0} >> src_i[4:0];

  always_comb begin
    res     = d_m;
    nf      = flags_i;
    upd_res = 1'b1;
    unique case (cmd_e'(cmd_i)) inside
      CMD_ADD, CMD_ADC: begin
        res   = add_t[DataW-1:0] & mask;
        nf.cf = carry_of(add_t, size_i);
        nf.of = msb_of(~(d_m ^ s_m) & (d_m ^ res), size_i);
      end
      CMD_SUB, CMD_SBB: begin
        res   = sub_t[DataW-1:0] & mask;
        nf.cf = borrow;
        nf.of = msb_of((d_m ^ s_m) & (d_m ^ res), size_i);
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        case (cmd_e'(cmd_i))
          CMD_AND: res = d_m & s_m;
          CMD_OR:  res = d_m | s_m;
          default: res = d_m ^ s_m;
        endcase
        nf.cf = 1'b0;
        nf.of = 1'b0;
      end
      CMD_SHL: begin
        if (!cnt_zero) begin
          if (cnt_lt) begin
            res   = shl_t[DataW-1:0] & mask;
            nf.cf = carry_of(shl_t, size_i);
          end else begin
            res   = '0;
            nf.cf = cnt_eq ? d_m[0] : 1'b0;
          end
          if (cnt_one) begin
            nf.of = msb_of(res, size_i) ^ nf.cf;
          end
        end
      end
      CMD_SHR: begin
        if (!cnt_zero) begin
          if (cnt_lt) begin
            res   = shr_t[DataW:1];
            nf.cf = shr_t[0];
          end else begin
            res   = '0;
            nf.cf = cnt_eq ? msb_of(d_m, size_i) : 1'b0;
          end
          if (cnt_one) begin
            nf.of = msb_of(d_m, size_i);
          end
        end
      end
      default: begin
        upd_res = 1'b0;
      end
    endcase
    if (upd_res) begin
      nf.pf = ~^res[7:0];
      nf.zf = (res == '0);
      nf.sf = msb_of(res, size_i);
    end
  end

  assign result_o = res;
  assign flags_o  = nf;

endmodule

`default_nettype wire

/* hw/rtl/x86_integer_alu_flags.sv */
// ----------------------------------------------------------------------------
// x86_integer_alu_flags
// x86-style 8/16/32-bit integer ALU keeping CF, PF, ZF, SF and OF.
// A request loads the input register when it is accepted; its result and flags
// load the result register once that register is empty or not stalled.
// Throughput: one request per cycle while the receiver does not stall the output;
// the flag register closes a loop through the ALU datapath.
// Reset clears the flags and both stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_integer_alu_flags
  import x86alu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [DataW-1:0] src_operand_i,
  input  logic [DataW-1:0] dest_operand_i,
  input  logic [SizeW-1:0] operand_size_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] result_value_o,
  output logic             carry_out_o,
  output logic             parity_out_o,
  output logic             zero_out_o,
  output logic             sign_out_o,
  output logic             overflow_out_o
);

  logic             s1_valid_q;
  logic [CmdW-1:0]  cmd_q;
  logic [DataW-1:0] src_q;
  logic [DataW-1:0] dest_q;
  logic [SizeW-1:0] size_q;

  logic             out_valid_q;
  logic [DataW-1:0] res_q;
  flags_t           out_flags_q;

  flags_t           flags_q;
  flags_t           flags_d;
  logic [DataW-1:0] res_d;

  logic             s2_ready;
  logic             s1_fire;
  logic             in_fire;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  x86alu_core u_core (
    .cmd_i    (cmd_q),
    .src_i    (src_q),
    .dest_i   (dest_q),
    .size_i   (size_q),
    .flags_i  (flags_q),
    .result_o (res_d),
    .flags_o  (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
      end else if (s2_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_i;
      src_q  <= src_operand_i;
      dest_q <= dest_operand_i;
      size_q <= operand_size_i;
    end
    if (s1_fire) begin
      res_q       <= res_d;
      out_flags_q <= flags_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign carry_out_o    = out_flags_q.cf;
  assign parity_out_o   = out_flags_q.pf;
  assign zero_out_o     = out_flags_q.zf;
  assign sign_out_o     = out_flags_q.sf;
  assign overflow_out_o = out_flags_q.of;

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held request");

  a_flags_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(flags_q))
    else $error("flags changed without a request");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (out_valid_q && (out_flags_q == flags_q)))
    else $error("result flags differ from stored flags");

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for x86_integer_alu_flags. A directed table covers the
// operand extremes, every operation, carry-in use, shift counts of zero, one,
// the width and beyond, the aliased size code and undefined opcodes. Random
// requests follow under several idle and stall mixes, with one long receiver
// hold-off. Results are checked against fixed rows or an in-bench flag model.
// ----------------------------------------------------------------------------
module tb;
  import x86alu_pkg::*;

  localparam int HalfPeriod = 2;
  localparam int ResetCycles = 5;
  localparam int HoldCycles = 60;
  localparam int IdleLimit = 2000;
  localparam int MaxReports = 10;
  localparam int NumDirected = 25;
  localparam int RandPerPhase = 230;
  localparam int DrainCycles = 4;

  localparam logic [CmdW-1:0] CmdUndefLo = 4'd9;
  localparam logic [CmdW-1:0] CmdUndefHi = 4'd15;
  localparam logic [SizeW-1:0] SzAlias32 = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] src;
    logic [DataW-1:0] dst;
    logic [SizeW-1:0] size;
  } alu_req_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    flags_t           flags;
  } alu_res_t;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] src;
    logic [DataW-1:0] dst;
    logic [SizeW-1:0] size;
    logic             fixed;
    logic [DataW-1:0] value;
    flags_t           flags;
  } dir_row_t;

  // flags column: cf pf zf sf of
  dir_row_t directed_tbl [NumDirected] = '{
    '{CMD_ADD, 32'h0000_0000, 32'h0000_0000, SZ_8,  1'b1, 32'h0000_0000, 5'b01100},
    '{CMD_ADD, 32'h0000_00FF, 32'h0000_0001, SZ_8,  1'b1, 32'h0000_0000, 5'b11100},
    '{CMD_ADC, 32'h0000_0000, 32'h0000_007F, SZ_8,  1'b1, 32'h0000_0080, 5'b00011},
    '{CMD_SUB, 32'h0000_0001, 32'h0000_0000, SZ_16, 1'b1, 32'h0000_FFFF, 5'b11010},
    '{CMD_SBB, 32'h0000_0000, 32'h0000_0000, SZ_32, 1'b1, 32'hFFFF_FFFF, 5'b11010},
    '{CMD_SUB, 32'h0000_0001, 32'h8000_0000, SZ_32, 1'b1, 32'h7FFF_FFFF, 5'b01001},
    '{CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SZ_32, 1'b1, 32'hFFFF_FFFE, 5'b10010},
    '{CMD_AND, 32'hFFFF_FFFF, 32'hA5A5_A5A5, SZ_32, 1'b1, 32'hA5A5_A5A5, 5'b01010},
    '{CMD_OR,  32'h1234_560F, 32'hFFFF_FFF0, SZ_8,  1'b1, 32'h0000_00FF, 5'b01010},
    '{CMD_XOR, 32'h0000_FFFF, 32'h0000_FFFF, SZ_16, 1'b1, 32'h0000_0000, 5'b01100},
    '{CMD_SHL, 32'h0000_0001, 32'h0000_0040, SZ_8,  1'b1, 32'h0000_0080, 5'b00011},
    '{CMD_SHL, 32'h0000_0000, 32'h0000_01FF, SZ_8,  1'b1, 32'h0000_00FF, 5'b01011},
    '{CMD_SHL, 32'h0000_0008, 32'h0000_0001, SZ_8,  1'b1, 32'h0000_0000, 5'b11101},
    '{CMD_SHL, 32'h0000_0011, 32'h0000_FFFF, SZ_16, 1'b1, 32'h0000_0000, 5'b01101},
    '{CMD_SHR, 32'h0000_0001, 32'h0000_0081, SZ_8,  1'b1, 32'h0000_0040, 5'b10001},
    '{CMD_SHR, 32'h0000_0020, 32'h8000_0000, SZ_32, 1'b1, 32'h0000_0000, 5'b11101},
    '{CMD_SHR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SZ_32, 1'b1, 32'h0000_0000, 5'b01101},
    '{CMD_SHR, 32'h0000_0003, 32'h0000_00F0, SZ_16, 1'b1, 32'h0000_001E, 5'b01001},
    '{CMD_SHL, 32'h0000_001F, 32'h0000_0003, SZ_32, 1'b1, 32'h8000_0000, 5'b11011},
    '{CMD_ADD, 32'h8000_0000, 32'h8000_0000, SzAlias32, 1'b1, 32'h0000_0000, 5'b11101},
    '{CmdUndefLo, 32'hDEAD_BEEF, 32'h1234_5678, SZ_16, 1'b1, 32'h0000_5678, 5'b11101},
    '{CmdUndefHi, 32'h0000_0000, 32'h0000_00FF, SZ_8,  1'b1, 32'h0000_00FF, 5'b11101},
    '{CMD_ADC, 32'h0000_FFFF, 32'h0000_0000, SZ_16, 1'b1, 32'h0000_0000, 5'b11100},
    '{CMD_SBB, 32'h0000_00FF, 32'h0000_00FF, SZ_8,  1'b1, 32'h0000_00FF, 5'b11010},
    '{CMD_SHR, 32'h0000_0009, 32'h0000_00FF, SZ_8,  1'b0, 32'h0000_0000, 5'b00000}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CmdW-1:0]  cmd_i;
  logic [DataW-1:0] src_operand_i;
  logic [DataW-1:0] dest_operand_i;
  logic [SizeW-1:0] operand_size_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [DataW-1:0] result_value_o;
  logic             carry_out_o;
  logic             parity_out_o;
  logic             zero_out_o;
  logic             sign_out_o;
  logic             overflow_out_o;

  // request side-band: typed-in expectation travelling with the payload
  logic     req_fixed;
  alu_res_t req_fixed_res;

  flags_t   model_flags = '0;
  alu_res_t result_q[$];
  int       error_cnt = 0;
  int       idle_pct;
  int       stall_pct;
  int       idle_cycles = 0;
  int       hold_cnt = 0;
  logic     hold_req;
  logic     hold_done = 1'b0;

  x86_integer_alu_flags i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .src_operand_i  (src_operand_i),
    .dest_operand_i (dest_operand_i),
    .operand_size_i (operand_size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .carry_out_o    (carry_out_o),
    .parity_out_o   (parity_out_o),
    .zero_out_o     (zero_out_o),
    .sign_out_o     (sign_out_o),
    .overflow_out_o (overflow_out_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic alu_res_t alu_predict(alu_req_t r);
    int unsigned width;
    logic [32:0] mask;
    logic [32:0] msb;
    logic [32:0] s;
    logic [32:0] d;
    logic [32:0] res;
    logic [32:0] sum;
    logic        cin;
    logic [31:0] cnt;
    alu_res_t    o;
    width = (r.size == SZ_8) ? 8 : (r.size == SZ_16) ? 16 : 32;
    mask  = (33'd1 << width) - 33'd1;
    msb   = 33'd1 << (width - 1);
    s     = {1'b0, r.src} & mask;
    d     = {1'b0, r.dst} & mask;
    cnt   = r.src;
    res   = d;
    cin   = 1'b0;
    case (r.cmd)
      CMD_ADD, CMD_ADC: begin
        cin = (r.cmd == CMD_ADC) ? model_flags.cf : 1'b0;
        sum = d + s + cin;
        res = sum & mask;
        model_flags.cf = sum[width];
        model_flags.of = |(~(d ^ s) & (d ^ res) & msb);
      end
      CMD_SUB, CMD_SBB: begin
        cin = (r.cmd == CMD_SBB) ? model_flags.cf : 1'b0;
        res = (d - s - cin) & mask;
        model_flags.cf = (d < s + cin);
        model_flags.of = |((d ^ s) & (d ^ res) & msb);
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        res = (r.cmd == CMD_AND) ? (d & s) : (r.cmd == CMD_OR) ? (d | s) : (d ^ s);
        model_flags.cf = 1'b0;
        model_flags.of = 1'b0;
      end
      CMD_SHL: begin
        if (cnt != 0) begin
          if (cnt < width) begin
            res = (d << cnt) & mask;
            model_flags.cf = d[width - cnt];
          end else begin
            res = '0;
            model_flags.cf = (cnt == width) ? d[0] : 1'b0;
          end
          if (cnt == 1) model_flags.of = res[width - 1] ^ model_flags.cf;
        end
      end
      CMD_SHR: begin
        if (cnt != 0) begin
          if (cnt < width) begin
            res = d >> cnt;
            model_flags.cf = d[cnt - 1];
          end else begin
            res = '0;
            model_flags.cf = (cnt == width) ? d[width - 1] : 1'b0;
          end
          if (cnt == 1) model_flags.of = d[width - 1];
        end
      end
      default: ;
    endcase
    // undefined opcodes leave every flag alone
    if (r.cmd <= CMD_SHR) begin
      model_flags.pf = ~^res[7:0];
      model_flags.zf = (res == 0);
      model_flags.sf = res[width - 1];
    end
    o.value = res[31:0];
    o.flags = model_flags;
    return o;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0000_007F << (8 * $urandom_range(0, 3));
      3:       return 32'h0000_0080 << (8 * $urandom_range(0, 3));
      4:       return 32'h0000_0001 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic alu_req_t random_request();
    alu_req_t r;
    if ($urandom_range(0, 99) < 6) r.cmd = CmdW'($urandom_range(CmdUndefLo, CmdUndefHi));
    else r.cmd = CmdW'($urandom_range(CMD_ADD, CMD_SHR));
    r.size = ($urandom_range(0, 99) < 8) ? SzAlias32 : SizeW'($urandom_range(SZ_8, SZ_32));
    r.dst  = pick_operand();
    if ((r.cmd == CMD_SHL || r.cmd == CMD_SHR) && $urandom_range(0, 99) < 80) begin
      case ($urandom_range(0, 3))
        0:       r.src = $urandom_range(0, 2);
        default: r.src = $urandom_range(0, 34);
      endcase
    end else begin
      r.src = pick_operand();
    end
    return r;
  endfunction

  task automatic send_request(input alu_req_t r, input logic fixed, input alu_res_t res);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= r.cmd;
    src_operand_i  <= r.src;
    dest_operand_i <= r.dst;
    operand_size_i <= r.size;
    req_fixed      <= fixed;
    req_fixed_res  <= res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic run_random(input int idle, input int stall, input logic hold);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_req <= 1'b1;
    repeat (RandPerPhase) send_request(random_request(), 1'b0, '0);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt + 1;
      if (hold_cnt == HoldCycles - 1) hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // scoreboard: check results first, then log newly accepted requests
  always @(posedge clk_i) begin
    alu_res_t exp_res;
    alu_res_t pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          error_cnt <= error_cnt + 1;
          if (error_cnt < MaxReports) $display("unexpected result %h", result_value_o);
        end else begin
          exp_res = result_q.pop_front();
          if (result_value_o !== exp_res.value || carry_out_o !== exp_res.flags.cf ||
              parity_out_o !== exp_res.flags.pf || zero_out_o !== exp_res.flags.zf ||
              sign_out_o !== exp_res.flags.sf || overflow_out_o !== exp_res.flags.of) begin
            error_cnt <= error_cnt + 1;
            if (error_cnt < MaxReports)
              $display("mismatch: exp %h cpzso=%b, got %h cpzso=%b%b%b%b%b",
                       exp_res.value, exp_res.flags, result_value_o, carry_out_o,
                       parity_out_o, zero_out_o, sign_out_o, overflow_out_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pred = alu_predict({cmd_i, src_operand_i, dest_operand_i, operand_size_i});
        result_q.push_back(req_fixed ? req_fixed_res : pred);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    alu_res_t res;
    alu_req_t r;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_ADD;
    src_operand_i  = '0;
    dest_operand_i = '0;
    operand_size_i = SZ_8;
    req_fixed      = 1'b0;
    req_fixed_res  = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) begin
      r   = '{directed_tbl[i].cmd, directed_tbl[i].src, directed_tbl[i].dst,
              directed_tbl[i].size};
      res = '{directed_tbl[i].value, directed_tbl[i].flags};
      send_request(r, directed_tbl[i].fixed, res);
    end

    run_random(0, 0, 1'b1);
    run_random(73, 0, 1'b0);
    run_random(0, 73, 1'b0);
    run_random(23, 23, 1'b0);
    in_valid_i <= 1'b0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_cnt == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
